[hdl/sbcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_pkg
// Widths, face codes and small helpers for the swept box collision face block.
// ----------------------------------------------------------------------------
package sbcf_pkg;

  localparam int WR   = 33;  // relative move, signed
  localparam int WQD  = 34;  // position difference before the move is added
  localparam int WPS  = 35;  // shifted Minkowski corner, signed
  localparam int WS   = 32;  // summed box size, unsigned
  localparam int WE   = 36;  // edge start point, signed
  localparam int WLO  = 17;  // low slice of a split multiplier operand
  localparam int WPP  = 51;  // partial product of a split multiply
  localparam int WPR  = 68;  // full product, signed
  localparam int WC   = 70;  // cross product sums, signed
  localparam int WN   = 33;  // normalised crossing numerator and denominator
  localparam int WXP  = 50;  // partial product of the time comparison
  localparam int WX   = 66;  // full product of the time comparison
  localparam int WDR  = 34;  // divider remainder
  localparam int NDIV = 16;  // quotient bits of the hit time
  localparam int NSTG = 28;  // pipeline stages, output register included

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    FACE_NONE   = 3'd0,
    FACE_TOP    = 3'd1,
    FACE_BOTTOM = 3'd2,
    FACE_LEFT   = 3'd3,
    FACE_RIGHT  = 3'd4
  } face_t;

  // True when n/d lies strictly between 0 and 1; a zero d never passes.
  function automatic logic in_unit(input logic signed [WC-1:0] n,
                                   input logic signed [WC-1:0] d);
    in_unit = (d > 0) ? ((n > 0) && (n < d)) : ((n < 0) && (n > d));
  endfunction

  function automatic logic [WN-1:0] abs_n(input logic signed [WE-1:0] a);
    logic signed [WE-1:0] neg;
    neg = -a;
    abs_n = a[WE-1] ? neg[WN-1:0] : a[WN-1:0];
  endfunction

endpackage

[hdl/swept_box_collision_face.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_face
// Finds the first face of box B that box A strikes during one step.
// ----------------------------------------------------------------------------
// One box pair enters per cycle while in_stall is low; the hit time is formed
// by the 16-stage restoring divider, which stands behind the split multipliers
// of the cross products and of the time compare.
// Stages with no transaction in them close up while the output is stalled,
// so input is still taken until the pipeline is full. hit_face is 0 none,
// 1 top, 2 bottom, 3 left, 4 right; hit_time is Q1.16, 65536 for no hit.
module swept_box_collision_face (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic        [30:0] a_w,
  input  logic        [30:0] a_h,
  input  logic signed [31:0] a_dx,
  input  logic signed [31:0] a_dy,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic        [30:0] b_w,
  input  logic        [30:0] b_h,
  input  logic signed [31:0] b_dx,
  input  logic signed [31:0] b_dy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [2:0]  hit_face,
  output logic        [16:0] hit_time
);

  localparam int WR   = sbcf_pkg::WR;
  localparam int WQD  = sbcf_pkg::WQD;
  localparam int WPS  = sbcf_pkg::WPS;
  localparam int WS   = sbcf_pkg::WS;
  localparam int WE   = sbcf_pkg::WE;
  localparam int WLO  = sbcf_pkg::WLO;
  localparam int WPP  = sbcf_pkg::WPP;
  localparam int WPR  = sbcf_pkg::WPR;
  localparam int WC   = sbcf_pkg::WC;
  localparam int WN   = sbcf_pkg::WN;
  localparam int WXP  = sbcf_pkg::WXP;
  localparam int WX   = sbcf_pkg::WX;
  localparam int WDR  = sbcf_pkg::WDR;
  localparam int NDIV = sbcf_pkg::NDIV;
  localparam int NSTG = sbcf_pkg::NSTG;

  logic [NSTG:1] v;
  logic [NSTG:1] adv;

  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    adv[NSTG] = !v[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: relative move, position differences, summed sizes.
  logic signed [WR-1:0]  s1_rx, s1_ry;
  logic signed [WQD-1:0] s1_qx, s1_qy;
  logic        [WS-1:0]  s1_sx, s1_sy;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_rx <= WR'(a_dx) - WR'(b_dx);
      s1_ry <= WR'(a_dy) - WR'(b_dy);
      s1_qx <= WQD'(a_x) - WQD'(b_x) - $signed({3'b000, b_w});
      s1_qy <= WQD'(a_y) - WQD'(b_y) - $signed({3'b000, b_h});
      s1_sx <= {1'b0, a_w} + {1'b0, b_w};
      s1_sy <= {1'b0, a_h} + {1'b0, b_h};
    end
  end

  // Stage 2: Minkowski corner.
  logic signed [WR-1:0]  s2_rx, s2_ry;
  logic signed [WPS-1:0] s2_px, s2_py;
  logic        [WS-1:0]  s2_sx, s2_sy;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_px <= WPS'(s1_qx) + WPS'(s1_rx);
      s2_py <= WPS'(s1_qy) + WPS'(s1_ry);
      s2_rx <= s1_rx;
      s2_ry <= s1_ry;
      s2_sx <= s1_sx;
      s2_sy <= s1_sy;
    end
  end

  // Stage 3: split products px*ry, sx*ry, py*rx, sy*rx and the far corner.
  logic signed [WPS-1:0] ma [4];
  logic signed [WR-1:0]  mb [4];
  logic signed [WPP-1:0] s3_pl [4];
  logic signed [WPP-1:0] s3_ph [4];
  logic signed [WPS-1:0] s3_px, s3_py;
  logic signed [WR-1:0]  s3_rx, s3_ry;
  logic signed [WE-1:0]  s3_ex, s3_ey;

  always_comb begin
    ma[0] = s2_px;
    ma[1] = $signed({{(WPS-WS){1'b0}}, s2_sx});
    ma[2] = s2_py;
    ma[3] = $signed({{(WPS-WS){1'b0}}, s2_sy});
    mb[0] = s2_ry;
    mb[1] = s2_ry;
    mb[2] = s2_rx;
    mb[3] = s2_rx;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 4; i++) begin
        s3_pl[i] <= $signed({1'b0, ma[i][WLO-1:0]}) * mb[i];
        s3_ph[i] <= $signed(ma[i][WPS-1:WLO]) * mb[i];
      end
      s3_ex <= WE'(s2_px) + $signed({{(WE-WS){1'b0}}, s2_sx});
      s3_ey <= WE'(s2_py) + $signed({{(WE-WS){1'b0}}, s2_sy});
      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_rx <= s2_rx;
      s3_ry <= s2_ry;
    end
  end

  // Stage 4: recombine the partial products.
  logic signed [WPR-1:0] s4_p [4];
  logic signed [WPS-1:0] s4_px, s4_py;
  logic signed [WR-1:0]  s4_rx, s4_ry;
  logic signed [WE-1:0]  s4_ex, s4_ey;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 4; i++) begin
        s4_p[i] <= (WPR'(s3_ph[i]) <<< WLO) + WPR'(s3_pl[i]);
      end
      s4_px <= s3_px;
      s4_py <= s3_py;
      s4_rx <= s3_rx;
      s4_ry <= s3_ry;
      s4_ex <= s3_ex;
      s4_ey <= s3_ey;
    end
  end

  // Stage 5: ex*ry and ey*rx for the far corner.
  logic signed [WC-1:0]  s5_ca, s5_cb;
  logic signed [WPR-1:0] s5_p [4];
  logic signed [WPS-1:0] s5_px, s5_py;
  logic signed [WR-1:0]  s5_rx, s5_ry;
  logic signed [WE-1:0]  s5_ex, s5_ey;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_ca <= WC'(s4_p[0]) + WC'(s4_p[1]);
      s5_cb <= WC'(s4_p[2]) + WC'(s4_p[3]);
      s5_p  <= s4_p;
      s5_px <= s4_px;
      s5_py <= s4_py;
      s5_rx <= s4_rx;
      s5_ry <= s4_ry;
      s5_ex <= s4_ex;
      s5_ey <= s4_ey;
    end
  end

  // Stage 6: edge cross products and the move segment tests.
  logic signed [WC-1:0] s6_nv [4];
  logic signed [WC-1:0] s6_dtb, s6_dlr;
  logic [3:0]           s6_uh;
  logic [WN-1:0]        s6_n [4];
  logic [WN-1:0]        s6_dx, s6_dy;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_nv[0] <= s5_ca - s5_cb;
      s6_nv[1] <= s5_ca - WC'(s5_p[2]);
      s6_nv[2] <= s5_cb - WC'(s5_p[0]);
      s6_nv[3] <= s5_cb - s5_ca;
      s6_dtb   <= WC'(s5_p[1]);
      s6_dlr   <= WC'(s5_p[3]);
      s6_uh[0] <= sbcf_pkg::in_unit(WC'(s5_ey), WC'(s5_ry));
      s6_uh[1] <= sbcf_pkg::in_unit(WC'(s5_py), WC'(s5_ry));
      s6_uh[2] <= sbcf_pkg::in_unit(WC'(s5_px), WC'(s5_rx));
      s6_uh[3] <= sbcf_pkg::in_unit(WC'(s5_ex), WC'(s5_rx));
      s6_n[0]  <= sbcf_pkg::abs_n(s5_ey);
      s6_n[1]  <= sbcf_pkg::abs_n(WE'(s5_py));
      s6_n[2]  <= sbcf_pkg::abs_n(WE'(s5_px));
      s6_n[3]  <= sbcf_pkg::abs_n(s5_ex);
      s6_dx    <= sbcf_pkg::abs_n(WE'(s5_rx));
      s6_dy    <= sbcf_pkg::abs_n(WE'(s5_ry));
    end
  end

  // Stage 7: edge parameter tests complete the hit flags.
  logic [3:0]    s7_hit;
  logic [WN-1:0] s7_n [4];
  logic [WN-1:0] s7_dx, s7_dy;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_hit[0] <= s6_uh[0] && sbcf_pkg::in_unit(s6_nv[0], s6_dtb);
      s7_hit[1] <= s6_uh[1] && sbcf_pkg::in_unit(s6_nv[1], s6_dtb);
      s7_hit[2] <= s6_uh[2] && sbcf_pkg::in_unit(s6_nv[2], s6_dlr);
      s7_hit[3] <= s6_uh[3] && sbcf_pkg::in_unit(s6_nv[3], s6_dlr);
      s7_n  <= s6_n;
      s7_dx <= s6_dx;
      s7_dy <= s6_dy;
    end
  end

  // Stage 8: within a pair the denominators agree, so numerators decide.
  // A larger crossing parameter is an earlier time; on a tie the first wins.
  logic          pick_b, pick_r;
  logic          s8_tb_hit, s8_lr_hit;
  logic [WN-1:0] s8_tb_n, s8_lr_n, s8_dx, s8_dy;
  sbcf_pkg::face_t s8_tb_face, s8_lr_face;

  assign pick_b = s7_hit[1] && (!s7_hit[0] || (s7_n[1] > s7_n[0]));
  assign pick_r = s7_hit[3] && (!s7_hit[2] || (s7_n[3] > s7_n[2]));

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_tb_hit  <= s7_hit[0] || s7_hit[1];
      s8_lr_hit  <= s7_hit[2] || s7_hit[3];
      s8_tb_n    <= pick_b ? s7_n[1] : s7_n[0];
      s8_lr_n    <= pick_r ? s7_n[3] : s7_n[2];
      s8_tb_face <= pick_b ? sbcf_pkg::FACE_BOTTOM : sbcf_pkg::FACE_TOP;
      s8_lr_face <= pick_r ? sbcf_pkg::FACE_RIGHT : sbcf_pkg::FACE_LEFT;
      s8_dx      <= s7_dx;
      s8_dy      <= s7_dy;
    end
  end

  // Stage 9: split products for the cross-multiplied time comparison.
  logic [WXP-1:0]  s9_al, s9_ah, s9_bl, s9_bh;
  logic            s9_tb_hit, s9_lr_hit;
  logic [WN-1:0]   s9_tb_n, s9_lr_n, s9_dx, s9_dy;
  sbcf_pkg::face_t s9_tb_face, s9_lr_face;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_al      <= WXP'(s8_tb_n[WLO-1:0]) * WXP'(s8_dx);
      s9_ah      <= WXP'(s8_tb_n[WN-1:WLO]) * WXP'(s8_dx);
      s9_bl      <= WXP'(s8_lr_n[WLO-1:0]) * WXP'(s8_dy);
      s9_bh      <= WXP'(s8_lr_n[WN-1:WLO]) * WXP'(s8_dy);
      s9_tb_hit  <= s8_tb_hit;
      s9_lr_hit  <= s8_lr_hit;
      s9_tb_n    <= s8_tb_n;
      s9_lr_n    <= s8_lr_n;
      s9_tb_face <= s8_tb_face;
      s9_lr_face <= s8_lr_face;
      s9_dx      <= s8_dx;
      s9_dy      <= s8_dy;
    end
  end

  // Stage 10: recombine.
  logic [WX-1:0]   s10_xa, s10_xb;
  logic            s10_tb_hit, s10_lr_hit;
  logic [WN-1:0]   s10_tb_n, s10_lr_n, s10_dx, s10_dy;
  sbcf_pkg::face_t s10_tb_face, s10_lr_face;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s10_xa      <= (WX'(s9_ah) << WLO) + WX'(s9_al);
      s10_xb      <= (WX'(s9_bh) << WLO) + WX'(s9_bl);
      s10_tb_hit  <= s9_tb_hit;
      s10_lr_hit  <= s9_lr_hit;
      s10_tb_n    <= s9_tb_n;
      s10_lr_n    <= s9_lr_n;
      s10_tb_face <= s9_tb_face;
      s10_lr_face <= s9_lr_face;
      s10_dx      <= s9_dx;
      s10_dy      <= s9_dy;
    end
  end

  // Stage 11: final face choice.
  logic            pick_lr;
  logic [WN-1:0]   s11_n, s11_d;
  sbcf_pkg::face_t s11_face;

  assign pick_lr = s10_lr_hit && (!s10_tb_hit || (s10_xa < s10_xb));

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      if (pick_lr) begin
        s11_face <= s10_lr_face;
        s11_n    <= s10_lr_n;
        s11_d    <= s10_dx;
      end else if (s10_tb_hit) begin
        s11_face <= s10_tb_face;
        s11_n    <= s10_tb_n;
        s11_d    <= s10_dy;
      end else begin
        s11_face <= sbcf_pkg::FACE_NONE;
        s11_n    <= '0;
        s11_d    <= WN'(1);
      end
    end
  end

  // Stage 12 loads the divider; stages 13 onwards each yield one bit of
  // (d - n) * 2^16 / d. The remainder stays below d whenever a face is hit.
  logic [WDR-1:0]  dr [NDIV+1];
  logic [WN-1:0]   dd [NDIV+1];
  logic [NDIV-1:0] dq [NDIV+1];
  sbcf_pkg::face_t df [NDIV+1];

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      dr[0] <= {1'b0, s11_d - s11_n};
      dd[0] <= s11_d;
      dq[0] <= '0;
      df[0] <= s11_face;
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [WDR-1:0] r2;
    logic           ge;

    assign r2 = {dr[j][WDR-2:0], 1'b0};
    assign ge = r2 >= {1'b0, dd[j]};

    always_ff @(posedge clk) begin
      if (adv[13+j]) begin
        dr[j+1] <= ge ? (r2 - {1'b0, dd[j]}) : r2;
        dd[j+1] <= dd[j];
        dq[j+1] <= {dq[j][NDIV-2:0], ge};
        df[j+1] <= df[j];
      end
    end
  end

  assign hit_face = df[NDIV];
  assign hit_time = (df[NDIV] == sbcf_pkg::FACE_NONE) ? sbcf_pkg::ONE_Q16
                                                      : {1'b0, dq[NDIV]};

  a_time_matches_face: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((hit_face == sbcf_pkg::FACE_NONE) == (hit_time == sbcf_pkg::ONE_Q16)))
    else $error("hit time and face disagree");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_face <= sbcf_pkg::FACE_RIGHT))
    else $error("face code out of range");

  a_entry_taken: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[1])
    else $error("accepted transaction did not enter the pipeline");

  a_divider_holds: assert property (@(posedge clk) disable iff (rst)
    (v[12] && !adv[12]) |=> (v[12] && $stable(dd[0]) && $stable(dr[0])))
    else $error("held divider stage lost or changed its transaction");

endmodule

[tb/tb_swept_box_collision_face.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_box_collision_face
// Self-checking bench: box pairs are driven through a valid/stall handshake,
// each accepted pair is predicted with exact integer arithmetic and every
// result is compared with the oldest prediction, under random idling.
// ----------------------------------------------------------------------------

typedef struct {
  sbcf_pkg::face_t face;
  logic [16:0]     t;
} hit_t;

class face_scoreboard;
  hit_t pending[$];
  int   errors;
  int   checked;
  int   faces_seen[5];

  // Tests n/d strictly inside (0,1); returns n and d with d made positive.
  static function bit unit_open(input longint signed n, input longint signed d,
                                output longint signed on, output longint signed od);
    on = n;
    od = d;
    if (d == 0) return 0;
    if (d < 0) begin
      on = -n;
      od = -d;
    end
    return (on > 0) && (on < od);
  endfunction

  static function bit unit_open_wide(input logic signed [127:0] n,
                                     input logic signed [127:0] d);
    if (d == 0) return 0;
    if (d > 0) return (n > 0) && (n < d);
    return (n < 0) && (n > d);
  endfunction

  function void note_pair(input longint signed ax, ay, aw, ah, adx, ady,
                          input longint signed bx, by, bw, bh, bdx, bdy);
    longint signed rx, ry, px, py, sx, sy, nu, du, bn, bd;
    longint signed ex[4], ey[4];
    logic signed [127:0] cr, nv, dv;
    sbcf_pkg::face_t best;
    hit_t h;
    rx = adx - bdx;
    ry = ady - bdy;
    px = ax - bx - bw + rx;
    py = ay - by - bh + ry;
    sx = aw + bw;
    sy = ah + bh;
    ex[0] = px + sx; ey[0] = py + sy;
    ex[1] = px + sx; ey[1] = py;
    ex[2] = px;      ey[2] = py + sy;
    ex[3] = px + sx; ey[3] = py + sy;
    best = sbcf_pkg::FACE_NONE;
    bn = 0;
    bd = 1;
    for (int k = 0; k < 4; k++) begin
      cr = 128'(ex[k]) * 128'(ry) - 128'(ey[k]) * 128'(rx);
      if (k < 2) begin
        nv = cr;
        dv = 128'(sx) * 128'(ry);
        if (!unit_open(ey[k], ry, nu, du)) continue;
      end else begin
        nv = -cr;
        dv = 128'(sy) * 128'(rx);
        if (!unit_open(ex[k], rx, nu, du)) continue;
      end
      if (!unit_open_wide(nv, dv)) continue;
      // A larger crossing fraction on the move means an earlier hit.
      if (best == sbcf_pkg::FACE_NONE ||
          128'(bn) * 128'(du) < 128'(nu) * 128'(bd)) begin
        best = sbcf_pkg::face_t'(k + 1);
        bn = nu;
        bd = du;
      end
    end
    h.face = best;
    h.t = (best == sbcf_pkg::FACE_NONE) ? sbcf_pkg::ONE_Q16
                                        : 17'((128'(bd - bn) << 16) / 128'(bd));
    pending.push_back(h);
  endfunction

  task report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0s: got %0d, expected %0d", what, got, want);
  endtask

  task check_result(input logic [2:0] f, input logic [16:0] t);
    hit_t h;
    if (pending.size() == 0) begin
      report("unexpected transaction", f, -1);
      return;
    end
    h = pending.pop_front();
    checked++;
    if (f <= 4) faces_seen[f]++;
    if (f !== h.face) report("hit_face", f, h.face);
    if (t !== h.t) report("hit_time", t, h.t);
  endtask
endclass

module tb_swept_box_collision_face;
  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] a_x, a_y, a_dx, a_dy, b_x, b_y, b_dx, b_dy;
  logic [30:0] a_w, a_h, b_w, b_h;
  logic [2:0]  hit_face;
  logic [16:0] hit_time;

  face_scoreboard sb;
  int send_idle, recv_idle;
  longint cycles;
  bit done;
  logic [383:0] ones_seen, zeros_seen;

  localparam longint LIMIT = 2000000;

  swept_box_collision_face dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("swept_box_collision_face regression: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(hit_face, hit_time);

  always @(negedge clk)
    out_stall <= !rst && ($urandom_range(99) < recv_idle);

  task automatic send_pair(input logic [383:0] v);
    a_x  <= v[31:0];    a_y  <= v[63:32];   a_w  <= v[94:64];  a_h  <= v[126:96];
    a_dx <= v[159:128]; a_dy <= v[191:160]; b_x  <= v[223:192]; b_y <= v[255:224];
    b_w  <= v[286:256]; b_h  <= v[318:288]; b_dx <= v[351:320]; b_dy <= v[383:352];
    ones_seen  = ones_seen | v;
    zeros_seen = zeros_seen | ~v;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pair($signed(a_x), $signed(a_y), a_w, a_h, $signed(a_dx), $signed(a_dy),
                 $signed(b_x), $signed(b_y), b_w, b_h, $signed(b_dx), $signed(b_dy));
    @(negedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  function automatic logic [383:0] pack(input int ax, ay, aw, ah, adx, ady,
                                        input int bx, by, bw, bh, bdx, bdy);
    return {32'(bdy), 32'(bdx), 1'b0, 31'(bh), 1'b0, 31'(bw), 32'(by), 32'(bx),
            32'(ady), 32'(adx), 1'b0, 31'(ah), 1'b0, 31'(aw), 32'(ay), 32'(ax)};
  endfunction

  // Mostly plausible geometry at a random scale, with some raw noise.
  function automatic logic [383:0] random_pair();
    logic [383:0] v;
    int sc, sz;
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 12; i++) v[i*32 +: 32] = $urandom;
      return v;
    end
    sc = $urandom_range(22, 12);
    sz = $urandom_range(sc);
    v = pack($signed($urandom) >>> (32 - sc), $signed($urandom) >>> (32 - sc),
             $urandom >> (32 - sz), $urandom >> (32 - sz),
             $signed($urandom) >>> (32 - sc), $signed($urandom) >>> (32 - sc),
             $signed($urandom) >>> (32 - sc), $signed($urandom) >>> (32 - sc),
             $urandom >> (32 - sz), $urandom >> (32 - sz),
             $signed($urandom) >>> (32 - sc), $signed($urandom) >>> (32 - sc));
    if ($urandom_range(7) == 0) v[159:128] = v[351:320];  // no relative x move
    if ($urandom_range(7) == 0) v[191:160] = v[383:352];  // no relative y move
    if ($urandom_range(9) == 0) v[94:64] = 0;
    return v;
  endfunction

  localparam int U = 65536;

  initial begin
    sb = new();
    cycles = 0;
    ones_seen = 0;
    zeros_seen = 0;
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    {a_x, a_y, a_w, a_h, a_dx, a_dy, b_x, b_y, b_w, b_h, b_dx, b_dy} = '0;
    send_idle = 32;
    recv_idle = 59;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // A moving down onto B's top, up into its bottom, right, left.
    send_pair(pack(0, -3*U, U, U, 0, 4*U, 0, 0, U, U, 0, 0));
    send_pair(pack(0, 3*U, U, U, 0, -4*U, 0, 0, U, U, 0, 0));
    send_pair(pack(-3*U, 0, U, U, 4*U, 0, 0, 0, U, U, 0, 0));
    send_pair(pack(3*U, 0, U, U, -4*U, 0, 0, 0, U, U, 0, 0));
    // Missing, parallel and stationary moves.
    send_pair(pack(0, -3*U, U, U, 10*U, 0, 0, 0, U, U, 0, 0));
    send_pair(pack(0, 0, U, U, 0, 0, 5*U, 5*U, U, U, 0, 0));
    // Touching exactly at the end of the step: boundary, no hit.
    send_pair(pack(0, -2*U, U, U, 0, U, 0, 0, U, U, 0, 0));
    // Diagonal corner strike, equal times on two faces.
    send_pair(pack(-2*U, -2*U, U, U, 2*U, 2*U, 0, 0, U, U, 0, 0));
    // Zero-sized boxes and overlapping start.
    send_pair(pack(0, -3*U, 0, 0, 0, 4*U, 0, 0, 0, 0, 0, 0));
    send_pair(pack(0, 0, 2*U, 2*U, U, U, U/2, U/2, U, U, 0, 0));
    // Both boxes moving.
    send_pair(pack(0, -3*U, U, U, 0, 2*U, 0, 0, U, U, 0, -2*U));
    // Field extremes.
    send_pair(pack(32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_pair(pack(32'h80000000, 32'h7fffffff, 0, 0, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000, 32'h7fffffff));
    send_pair({384{1'b1}});
    send_pair('0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 59 : 0;
      recv_idle = (ph == 0) ? 59 : (ph == 1) ? 32 : 0;
      for (int i = 0; i < 545; i++) send_pair(random_pair());
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d pairs; faces none/top/bottom/left/right: %0d/%0d/%0d/%0d/%0d",
             sb.checked, sb.faces_seen[0], sb.faces_seen[1], sb.faces_seen[2],
             sb.faces_seen[3], sb.faces_seen[4]);
    $display("input bits toggled both ways: %0d of 384",
             $countones(ones_seen & zeros_seen));
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("swept_box_collision_face regression: pass");
    else
      $display("swept_box_collision_face regression: fail");
    $finish;
  end
endmodule

[files.f]
hdl/sbcf_pkg.sv
hdl/swept_box_collision_face.sv
tb/tb_swept_box_collision_face.sv
